/* rtl/scc_pkg.sv */
package scc_pkg;

   // Operating mode of the sequencer
   typedef enum logic [1:0] {
      MODE_OFF       = 2'd0,
      MODE_ARMED     = 2'd1,
      MODE_GOING     = 2'd2,
      MODE_RETURNING = 2'd3
   } mode_type;

   // Command codes carried in req_tuser
   typedef enum logic [2:0] {
      ACT_SET_ENABLE = 3'd0,
      ACT_START      = 3'd1,
      ACT_EDGE       = 3'd2,
      ACT_POLL       = 3'd3,
      ACT_STEP       = 3'd4
   } action_type;

   localparam int unsigned ActionW  = 3;
   localparam int unsigned SpeedW   = 16;
   localparam int unsigned RecordW  = 16;
   localparam int unsigned ReqDataW = 8;
   localparam int unsigned RspDataW = 40;

   // Result tdata bit positions
   localparam int unsigned RspStopBit  = 0;
   localparam int unsigned RspRunBit   = 1;
   localparam int unsigned RspFwdBit   = 2;
   localparam int unsigned RspSpeedLsb = 3;
   localparam int unsigned RspModeLsb  = 19;
   localparam int unsigned RspRecLsb   = 21;

endpackage

/* rtl/step_counted_oscillation_controller.sv */
// Channel   Ports                         Direction  Payload
// req       req_tvalid/tready/tdata/tuser in         tuser: action; tdata: levels, direction
// rsp       rsp_tvalid/tready/tdata       out        stop/run command, speed, mode, recorded
// csr       csr_valid/ready/wdata         in         run_speed register write
//
// One item per cycle unless the result stalls: each command is decoded and the state
// updated in the cycle it is accepted, its result registered together with the state.
// The output register alone sets the rate; req_tready is high whenever that
// register is empty or being drained in the same cycle.
// Reset is synchronous, active high: mode off, counts zero, initial direction forward.
// A stalled result holds the input side; a CSR write is always taken at once.
module step_counted_oscillation_controller #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Command stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [0] enable_level, [1] start_forward, [2] sensor_level, [7:3] zero
   input  logic [scc_pkg::ReqDataW-1:0]  req_tdata,
   // [2:0] action
   input  logic [scc_pkg::ActionW-1:0]   req_tuser,
   // Result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] stop_now, [1] run_now, [2] run_forward, [18:3] speed_out,
   // [20:19] mode_out, [36:21] recorded_out, [39:37] zero
   output logic [scc_pkg::RspDataW-1:0]  rsp_tdata,
   // Configuration write: run_speed
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [scc_pkg::SpeedW-1:0]    csr_wdata
);
   import scc_pkg::*;

   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   // Architectural state
   mode_type              mode_ff, mode_in;
   logic [COUNT_BITS-1:0] outward_ff, outward_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  init_fwd_ff, init_fwd_in;
   logic                  prev_sens_ff, prev_sens_in;
   logic [SpeedW-1:0]     run_speed_ff;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]   rsp_data_ff, rsp_data_in;

   logic                  req_xfer;
   logic                  en_lvl, start_fwd, sens_lvl;
   logic                  cmd_stop, cmd_run, cmd_fwd;
   logic [31:0]           outward_ext;

   assign en_lvl    = req_tdata[0];
   assign start_fwd = req_tdata[1];
   assign sens_lvl  = req_tdata[2];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      mode_in      = mode_ff;
      outward_in   = outward_ff;
      count_in     = count_ff;
      init_fwd_in  = init_fwd_ff;
      prev_sens_in = prev_sens_ff;
      cmd_stop     = 1'b0;
      cmd_run      = 1'b0;
      cmd_fwd      = 1'b0;

      unique case (req_tuser)
         ACT_SET_ENABLE: begin
            if (en_lvl) begin
               if (mode_ff == MODE_OFF) mode_in = MODE_ARMED;
            end else if (mode_ff != MODE_OFF) begin
               // Disable: hard stop, drop back to off
               cmd_stop = 1'b1;
               mode_in  = MODE_OFF;
            end
         end
         ACT_START: begin
            if (mode_ff == MODE_ARMED) begin
               // Latch direction and sensor level, run outward from zero
               init_fwd_in  = start_fwd;
               prev_sens_in = sens_lvl;
               outward_in   = '0;
               count_in     = '0;
               cmd_run      = 1'b1;
               cmd_fwd      = start_fwd;
               mode_in      = MODE_GOING;
            end
         end
         ACT_EDGE: begin
            if (mode_ff == MODE_GOING) begin
               // Record the outward leg, stop and reverse
               outward_in = count_ff;
               count_in   = '0;
               cmd_stop   = 1'b1;
               cmd_run    = 1'b1;
               cmd_fwd    = !init_fwd_ff;
               mode_in    = MODE_RETURNING;
            end
         end
         ACT_POLL: begin
            prev_sens_in = sens_lvl;
            if (mode_ff == MODE_GOING) begin
               if (sens_lvl != prev_sens_ff) begin
                  outward_in = count_ff;
                  count_in   = '0;
                  cmd_stop   = 1'b1;
                  cmd_run    = 1'b1;
                  cmd_fwd    = !init_fwd_ff;
                  mode_in    = MODE_RETURNING;
               end
            end else if (mode_ff == MODE_RETURNING) begin
               // Back at the start point: stop and head outward again
               if (count_ff >= outward_ff) begin
                  count_in = '0;
                  cmd_stop = 1'b1;
                  cmd_run  = 1'b1;
                  cmd_fwd  = init_fwd_ff;
                  mode_in  = MODE_GOING;
               end
            end
         end
         ACT_STEP: begin
            // Saturating step count
            if (count_ff != CountMax) count_in = count_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign outward_ext = 32'(outward_in);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RspStopBit] = cmd_stop;
      rsp_data_in[RspRunBit]  = cmd_run;
      rsp_data_in[RspFwdBit]  = cmd_fwd;
      rsp_data_in[RspSpeedLsb +: SpeedW]  = cmd_run ? run_speed_ff : '0;
      rsp_data_in[RspModeLsb +: 2]        = mode_in;
      rsp_data_in[RspRecLsb +: RecordW]   = outward_ext[RecordW-1:0];
   end

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         outward_ff   <= '0;
         count_ff     <= '0;
         init_fwd_ff  <= 1'b1;
         prev_sens_ff <= 1'b0;
         run_speed_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            mode_ff      <= mode_in;
            outward_ff   <= outward_in;
            count_ff     <= count_in;
            init_fwd_ff  <= init_fwd_in;
            prev_sens_ff <= prev_sens_in;
         end
         if (csr_valid) run_speed_ff <= csr_wdata;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result on each accepted command, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/scc_checker.sv */
module scc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [scc_pkg::RspDataW-1:0]  rsp_tdata
);
   import scc_pkg::*;

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Direction and speed are zero unless a run is commanded
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RspRunBit] |->
         rsp_tdata[RspFwdBit] == 1'b0 && rsp_tdata[RspSpeedLsb +: SpeedW] == '0)
      else $error("direction or speed without run");

   // A run always leaves the motor going or returning
   a_run_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RspRunBit] |->
         rsp_tdata[RspModeLsb +: 2] == MODE_GOING ||
         rsp_tdata[RspModeLsb +: 2] == MODE_RETURNING)
      else $error("run command outside a run mode");

   // A stop without a run is only the disable path
   a_stop_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RspStopBit] && !rsp_tdata[RspRunBit] |->
         rsp_tdata[RspModeLsb +: 2] == MODE_OFF)
      else $error("bare stop while not off");

endmodule

bind step_counted_oscillation_controller scc_checker u_scc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* verif/tb_step_counted_oscillation_controller.sv */
module tb_step_counted_oscillation_controller;
   import scc_pkg::*;

   localparam int unsigned CountBits     = 16;
   localparam logic [CountBits-1:0] CountMax = '1;
   localparam int unsigned ItemsPerPhase = 356;
   localparam int unsigned NumPhases     = 5;
   localparam int unsigned WatchdogLimit = 4000;
   localparam int unsigned NumDrill      = 28;

   // Action codes the block must ignore
   localparam logic [ActionW-1:0] ActUnusedLo = 3'd5;
   localparam logic [ActionW-1:0] ActUnusedHi = 3'd7;

   typedef struct packed {
      logic [ActionW-1:0] action;
      logic               en;
      logic               sfwd;
      logic               sens;
   } osc_req_type;

   typedef struct packed {
      logic               stop;
      logic               run;
      logic               fwd;
      logic [SpeedW-1:0]  speed;
      mode_type           mode;
      logic [RecordW-1:0] rec;
   } osc_rsp_type;

   typedef struct packed {
      osc_req_type cmd;
      logic [31:0] reps;
      logic        typed;
      osc_rsp_type want;
   } drill_row_type;

   localparam osc_rsp_type QuietOff   = '{1'b0, 1'b0, 1'b0, 16'd0, MODE_OFF, 16'd0};
   localparam osc_rsp_type QuietArmed = '{1'b0, 1'b0, 1'b0, 16'd0, MODE_ARMED, 16'd0};
   localparam osc_rsp_type QuietGoing = '{1'b0, 1'b0, 1'b0, 16'd0, MODE_GOING, 16'd0};

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [ReqDataW-1:0]  req_tdata;
   logic [ActionW-1:0]   req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RspDataW-1:0]  rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [SpeedW-1:0]    csr_wdata;

   step_counted_oscillation_controller #(
      .COUNT_BITS(CountBits)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // Sequencer shadow state, advanced once per accepted command transfer
   mode_type             seq_mode        = MODE_OFF;
   logic [CountBits-1:0] seq_outward     = '0;
   logic [CountBits-1:0] seq_count       = '0;
   logic                 seq_init_fwd    = 1'b1;
   logic                 seq_prev_sensor = 1'b0;
   logic [SpeedW-1:0]    seq_speed       = '0;

   osc_rsp_type pending_commands [$];
   int unsigned mismatches      = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct   = 0;
   int unsigned quiet_cycles    = 0;

   // Directed walk: each corner first, then a full out-and-back cycle,
   // a longer outward leg and the enable drop from every busy mode.
   drill_row_type drill_rows [NumDrill] = '{
      '{'{ACT_POLL,       1'b0, 1'b0, 1'b1}, 32'd1, 1'b1, QuietOff},   // poll while off
      '{'{ACT_SET_ENABLE, 1'b0, 1'b0, 1'b0}, 32'd1, 1'b1, QuietOff},   // low while off: no stop
      '{'{ACT_EDGE,       1'b0, 1'b0, 1'b0}, 32'd1, 1'b1, QuietOff},
      '{'{ACT_START,      1'b0, 1'b1, 1'b0}, 32'd1, 1'b1, QuietOff},
      '{'{ActUnusedHi,    1'b1, 1'b1, 1'b1}, 32'd1, 1'b1, QuietOff},
      '{'{ACT_SET_ENABLE, 1'b1, 1'b0, 1'b0}, 32'd1, 1'b1, QuietArmed},
      '{'{ACT_SET_ENABLE, 1'b1, 1'b0, 1'b0}, 32'd1, 1'b1, QuietArmed}, // high again
      '{'{ACT_POLL,       1'b0, 1'b0, 1'b0}, 32'd1, 1'b1, QuietArmed},
      '{'{ACT_START,      1'b0, 1'b1, 1'b1}, 32'd1, 1'b1,
        '{1'b0, 1'b1, 1'b1, 16'd0, MODE_GOING, 16'd0}},
      '{'{ACT_POLL,       1'b0, 1'b0, 1'b1}, 32'd1, 1'b1, QuietGoing}, // level held at start
      '{'{ACT_STEP,       1'b0, 1'b0, 1'b0}, 32'd3, 1'b0, '0},
      '{'{ACT_POLL,       1'b0, 1'b0, 1'b0}, 32'd1, 1'b1,
        '{1'b1, 1'b1, 1'b0, 16'd0, MODE_RETURNING, 16'd3}},
      '{'{ACT_POLL,       1'b0, 1'b0, 1'b0}, 32'd1, 1'b0, '0},         // short of the mark
      '{'{ACT_STEP,       1'b0, 1'b0, 1'b0}, 32'd3, 1'b0, '0},
      '{'{ACT_POLL,       1'b0, 1'b0, 1'b1}, 32'd1, 1'b0, '0},         // back home
      '{'{ACT_STEP,       1'b1, 1'b1, 1'b1}, 32'd40, 1'b0, '0},        // longer outward leg
      '{'{ACT_EDGE,       1'b0, 1'b0, 1'b0}, 32'd1, 1'b1,
        '{1'b1, 1'b1, 1'b0, 16'd0, MODE_RETURNING, 16'd40}},
      '{'{ActUnusedLo,    1'b0, 1'b0, 1'b0}, 32'd1, 1'b0, '0},
      '{'{ACT_SET_ENABLE, 1'b0, 1'b0, 1'b0}, 32'd1, 1'b1,
        '{1'b1, 1'b0, 1'b0, 16'd0, MODE_OFF, 16'd40}},
      '{'{ACT_SET_ENABLE, 1'b1, 1'b0, 1'b0}, 32'd1, 1'b0, '0},
      '{'{ACT_START,      1'b0, 1'b0, 1'b0}, 32'd1, 1'b1,
        '{1'b0, 1'b1, 1'b0, 16'd0, MODE_GOING, 16'd0}},
      '{'{ACT_EDGE,       1'b0, 1'b0, 1'b0}, 32'd1, 1'b0, '0},         // zero-length leg
      '{'{ACT_POLL,       1'b0, 1'b0, 1'b1}, 32'd1, 1'b0, '0},
      '{'{ACT_SET_ENABLE, 1'b1, 1'b0, 1'b0}, 32'd1, 1'b0, '0},
      '{'{ACT_START,      1'b0, 1'b1, 1'b1}, 32'd1, 1'b0, '0},         // start while going
      '{'{ACT_SET_ENABLE, 1'b0, 1'b0, 1'b0}, 32'd1, 1'b0, '0},
      '{'{ACT_SET_ENABLE, 1'b1, 1'b0, 1'b0}, 32'd1, 1'b0, '0},
      '{'{ACT_EDGE,       1'b0, 1'b0, 1'b0}, 32'd1, 1'b0, '0}          // edge while armed
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sensor edge on the outward leg: record the count and turn around
   function automatic void take_sensor_edge(inout osc_rsp_type r);
      if (seq_mode == MODE_GOING) begin
         seq_outward = seq_count;
         seq_count   = '0;
         r.stop      = 1'b1;
         r.run       = 1'b1;
         r.fwd       = ~seq_init_fwd;
         seq_mode    = MODE_RETURNING;
      end
   endfunction

   function automatic osc_rsp_type advance_sequencer(input osc_req_type c);
      osc_rsp_type r;
      logic        changed;
      r = '0;
      case (c.action)
         ACT_SET_ENABLE: begin
            if (c.en) begin
               if (seq_mode == MODE_OFF) seq_mode = MODE_ARMED;
            end else if (seq_mode != MODE_OFF) begin
               r.stop   = 1'b1;
               seq_mode = MODE_OFF;
            end
         end
         ACT_START: begin
            if (seq_mode == MODE_ARMED) begin
               seq_init_fwd    = c.sfwd;
               seq_prev_sensor = c.sens;
               seq_outward     = '0;
               seq_count       = '0;
               r.run           = 1'b1;
               r.fwd           = c.sfwd;
               seq_mode        = MODE_GOING;
            end
         end
         ACT_EDGE: take_sensor_edge(r);
         ACT_POLL: begin
            changed         = (c.sens != seq_prev_sensor);
            seq_prev_sensor = c.sens;
            if (seq_mode == MODE_GOING) begin
               if (changed) take_sensor_edge(r);
            end else if (seq_mode == MODE_RETURNING && seq_count >= seq_outward) begin
               seq_count = '0;
               r.stop    = 1'b1;
               r.run     = 1'b1;
               r.fwd     = seq_init_fwd;
               seq_mode  = MODE_GOING;
            end
         end
         ACT_STEP: begin
            if (seq_count != CountMax) seq_count = seq_count + 1'b1;
         end
         default: ;
      endcase
      if (r.run) r.speed = seq_speed;
      r.mode = seq_mode;
      r.rec  = seq_outward[RecordW-1:0];
      return r;
   endfunction

   // Mostly well-formed oscillation traffic, steered by the shadow mode,
   // with a tenth of fully random noise
   function automatic osc_req_type pick_command();
      osc_req_type c;
      int unsigned roll;
      roll   = $urandom_range(99);
      c.en   = 1'($urandom_range(1));
      c.sfwd = 1'($urandom_range(1));
      c.sens = 1'($urandom_range(1));
      c.action = ACT_STEP;
      if (roll < 10) begin
         c.action = 3'($urandom_range(7));
      end else begin
         case (seq_mode)
            MODE_OFF: begin
               if (roll < 70) begin
                  c.action = ACT_SET_ENABLE;
                  c.en     = 1'b1;
               end else if (roll < 80) c.action = ACT_SET_ENABLE;
               else if (roll < 90) c.action = ACT_POLL;
            end
            MODE_ARMED: begin
               if (roll < 65) c.action = ACT_START;
               else if (roll < 75) c.action = ACT_POLL;
               else if (roll < 85) c.action = ACT_STEP;
               else if (roll < 92) c.action = ACT_EDGE;
               else c.action = ACT_SET_ENABLE;
            end
            MODE_GOING: begin
               if (roll < 50) c.action = ACT_STEP;
               else if (roll < 85) c.action = ACT_POLL;
               else if (roll < 93) c.action = ACT_EDGE;
               else if (roll < 97) c.action = ACT_START;
               else c.action = ACT_SET_ENABLE;
            end
            default: begin
               if (roll < 55) c.action = ACT_STEP;
               else if (roll < 93) c.action = ACT_POLL;
               else if (roll < 97) c.action = ACT_EDGE;
               else c.action = ACT_SET_ENABLE;
            end
         endcase
      end
      return c;
   endfunction

   // Drive one command, hold it until the transfer, then queue its expectation
   task automatic send_command(input osc_req_type cmd, input logic typed,
                               input osc_rsp_type want);
      int unsigned gap;
      osc_rsp_type predicted;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd.action;
      req_tdata  <= {5'b0, cmd.sens, cmd.sfwd, cmd.en};
      do @(posedge clock); while (!req_tready);
      predicted = advance_sequencer(cmd);
      pending_commands.push_back(typed ? want : predicted);
   endtask

   // Drain the result stream, then write run_speed while the block is idle
   task automatic write_speed(input logic [SpeedW-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      seq_speed = value;
   endtask

   task automatic check_response(input osc_rsp_type got);
      osc_rsp_type want;
      if (pending_commands.size() == 0) begin
         $error("result transfer with no command outstanding: %h", got);
         mismatches++;
      end else begin
         want = pending_commands.pop_front();
         if (got.stop !== want.stop) begin
            $error("stop_now: expected %0d, actual %0d", want.stop, got.stop);
            mismatches++;
         end
         if (got.run !== want.run) begin
            $error("run_now: expected %0d, actual %0d", want.run, got.run);
            mismatches++;
         end
         if (got.fwd !== want.fwd) begin
            $error("run_forward: expected %0d, actual %0d", want.fwd, got.fwd);
            mismatches++;
         end
         if (got.speed !== want.speed) begin
            $error("speed_out: expected %0d, actual %0d", want.speed, got.speed);
            mismatches++;
         end
         if (got.mode !== want.mode) begin
            $error("mode_out: expected %0d, actual %0d", want.mode, got.mode);
            mismatches++;
         end
         if (got.rec !== want.rec) begin
            $error("recorded_out: expected %0d, actual %0d", want.rec, got.rec);
            mismatches++;
         end
      end
   endtask

   // Result side: stall at the phase's rate, sample on the transfer edge
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready)
         check_response('{rsp_tdata[RspStopBit], rsp_tdata[RspRunBit], rsp_tdata[RspFwdBit],
                          rsp_tdata[RspSpeedLsb +: SpeedW],
                          mode_type'(rsp_tdata[RspModeLsb +: 2]),
                          rsp_tdata[RspRecLsb +: RecordW]});
   end

   // Abort if no transfer of any kind happens for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [SpeedW-1:0] phase_speed [NumPhases];
      int unsigned       phase_idle  [NumPhases];
      int unsigned       phase_stall [NumPhases];
      int unsigned       row;
      int unsigned       rep;
      int unsigned       phase;
      int unsigned       k;
      phase_speed = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0001, 16'($urandom)};
      phase_idle  = '{0, 54, 0, 34, 0};
      phase_stall = '{0, 0, 54, 34, 0};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_SET_ENABLE;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      rsp_tready <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rows run at the reset speed with no idling
      for (row = 0; row < NumDrill; row++)
         for (rep = 0; rep < drill_rows[row].reps; rep++)
            send_command(drill_rows[row].cmd, drill_rows[row].typed, drill_rows[row].want);

      for (phase = 0; phase < NumPhases; phase++) begin
         write_speed(phase_speed[phase]);
         sender_idle_pct = phase_idle[phase];
         rsp_stall_pct   = phase_stall[phase];
         for (k = 0; k < ItemsPerPhase; k++)
            send_command(pick_command(), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/scc_pkg.sv
rtl/step_counted_oscillation_controller.sv
rtl/scc_checker.sv
verif/tb_step_counted_oscillation_controller.sv
